>>> src/bgi_pkg.sv
package bgi_pkg;

	localparam int THETA_POINTS_DEF = 64;
	localparam int Z_POINTS_DEF = 16;

	// command queue and result queue depths
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	localparam int VAL_W = 32;
	localparam int CFG_W = 7;
	localparam int TUSED_W = 7;
	localparam int ZUSED_W = 5;
	localparam logic [TUSED_W-1:0] THETA_USED_RST = 7'd64;
	localparam logic [ZUSED_W-1:0] Z_USED_RST = 5'd16;

	localparam int PROD_W = 64;
	localparam int TERM_W = 96;
	localparam int ACC_W = 99;
	localparam int MAG_W = 98;
	localparam int DEN_W = 64;
	localparam int QUO_W = 32;

	localparam logic [VAL_W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] NEG_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		KIND_LOAD_THETA,
		KIND_LOAD_Z,
		KIND_LOAD_GRID,
		KIND_QUERY
	} kind_t;

	typedef enum logic {
		REG_THETA_USED,
		REG_Z_USED
	} reg_idx_t;

	typedef struct packed {
		kind_t              kind;
		logic [5:0]         theta_index;
		logic [3:0]         z_index;
		logic signed [31:0] load_value;
		logic signed [31:0] query_theta;
		logic signed [31:0] query_z;
	} item_t;

	typedef struct packed {
		logic signed [31:0] interpolated;
		logic               saturated;
		logic               degenerate_cell;
	} result_t;

	// opa: load value or query theta, opb: query z
	typedef struct packed {
		kind_t              op;
		logic [5:0]         tidx;
		logic [3:0]         zidx;
		logic signed [31:0] opa;
		logic signed [31:0] opb;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic big;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRD,
		ST_TCMP,
		ST_ZRD,
		ST_ZCMP,
		ST_FETCH,
		ST_DIFF,
		ST_DEN,
		ST_DEN2,
		ST_MAC,
		ST_NORM,
		ST_DSTART,
		ST_DIV,
		ST_OUT
	} back_state_t;

	function automatic logic [31:0] mag33(input logic [32:0] v);
		logic [32:0] n;
		n = v[32] ? (~v + 33'd1) : v;
		return n[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

>>> src/bgi_ram.sv
module bgi_ram #(
	parameter int W = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/bgi_fifo.sv
module bgi_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_wr, do_rd})
				2'b10: cnt_q <= cnt_q + CW'(1);
				2'b01: cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> src/bgi_front.sv
module bgi_front #(
	parameter int THETA_POINTS = bgi_pkg::THETA_POINTS_DEF,
	parameter int Z_POINTS = bgi_pkg::Z_POINTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  bgi_pkg::item_t item,
	input  logic           cmd_pop,
	output bgi_pkg::cmd_t  cmd,
	output logic           cmd_empty
);

	bgi_pkg::cmd_t cmd_c;
	logic          t_ok, z_ok, keep;

	assign t_ok = int'(item.theta_index) < THETA_POINTS;
	assign z_ok = int'(item.z_index) < Z_POINTS;

	// loads aimed past the end of a store are dropped here
	always_comb begin
		unique case (item.kind)
			bgi_pkg::KIND_LOAD_THETA: keep = t_ok;
			bgi_pkg::KIND_LOAD_Z:     keep = z_ok;
			bgi_pkg::KIND_LOAD_GRID:  keep = t_ok && z_ok;
			bgi_pkg::KIND_QUERY:      keep = 1'b1;
			default:                  keep = 1'b0;
		endcase
		cmd_c.op = item.kind;
		cmd_c.tidx = item.theta_index;
		cmd_c.zidx = item.z_index;
		cmd_c.opa = (item.kind == bgi_pkg::KIND_QUERY) ? item.query_theta : item.load_value;
		cmd_c.opb = item.query_z;
	end

	bgi_fifo #(
		.W($bits(bgi_pkg::cmd_t)),
		.DEPTH(bgi_pkg::CMD_DEPTH)
	) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push && keep),
		.wr_data(cmd_c),
		.full(full),
		.rd_en(cmd_pop),
		.rd_data(cmd),
		.empty(cmd_empty)
	);

endmodule

>>> src/bgi_div.sv
module bgi_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bgi_pkg::MAG_W-1:0]   num,
	input  logic [bgi_pkg::DEN_W-1:0]   den,
	output logic [bgi_pkg::QUO_W-1:0]   quo,
	output bgi_pkg::div_stat_t          stat
);

	localparam int QW = bgi_pkg::QUO_W;
	localparam int DW = bgi_pkg::DEN_W;
	localparam int MW = bgi_pkg::MAG_W;
	localparam int CW = $clog2(QW + 1);

	logic          busy_q, big_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q, den_q;
	logic [QW-1:0] lo_q;
	logic [DW:0]   trial, diff;
	logic          fits;

	assign trial = {rem_q, lo_q[QW-1]};
	assign diff = trial - {1'b0, den_q};
	assign fits = trial >= {1'b0, den_q};
	assign quo = lo_q;
	assign stat.busy = busy_q;
	assign stat.big = big_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// quotient of 2^32 or more saturates; otherwise the top part is the first remainder
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			big_q <= num[MW-1:QW] >= (MW - QW)'(den);
			rem_q <= num[QW+DW-1:QW];
			lo_q <= num[QW-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			lo_q <= {lo_q[QW-2:0], fits};
		end
	end

endmodule

>>> src/bgi_back.sv
module bgi_back #(
	parameter int THETA_POINTS = bgi_pkg::THETA_POINTS_DEF,
	parameter int Z_POINTS = bgi_pkg::Z_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  bgi_pkg::reg_idx_t             cfg_index,
	input  logic [bgi_pkg::CFG_W-1:0]     cfg_data,
	input  bgi_pkg::cmd_t                 cmd,
	input  logic                          cmd_empty,
	output logic                          cmd_pop,
	output bgi_pkg::result_t              res,
	output logic                          res_push,
	input  logic                          res_full
);

	localparam int TAW = $clog2(THETA_POINTS);
	localparam int ZAW = $clog2(Z_POINTS);
	localparam int GDEPTH = THETA_POINTS * Z_POINTS;
	localparam int GAW = $clog2(GDEPTH);
	localparam int NTW = $clog2(THETA_POINTS + 1);
	localparam int NZW = $clog2(Z_POINTS + 1);
	localparam int AW = bgi_pkg::ACC_W;
	localparam int MW = bgi_pkg::MAG_W;

	bgi_pkg::back_state_t state_q, state_d;

	logic [bgi_pkg::TUSED_W-1:0] theta_used_q;
	logic [bgi_pkg::ZUSED_W-1:0] z_used_q;
	logic [NTW-1:0] nt_q, ti_q, nt_c;
	logic [NZW-1:0] nz_q, zi_q, nz_c;
	logic [2:0]     k_q, ph_q;
	logic [1:0]     j_q;

	logic [31:0] qt_q, qz_q, tlo_q, thi_q, zlo_q, zhi_q;
	logic [31:0] g_q [4];
	logic [31:0] dth_m_q, dtl_m_q, dzh_m_q, dzl_m_q, ddt_m_q, ddz_m_q;
	logic        dth_s_q, dtl_s_q, dzh_s_q, dzl_s_q, dneg_q, qneg_q;
	logic [bgi_pkg::PROD_W-1:0] prod_q;
	logic [bgi_pkg::DEN_W-1:0]  den_q;
	logic [31:0]                mhi_q;
	logic [bgi_pkg::TERM_W-1:0] term_q;
	logic [AW-1:0]              acc_q;
	logic [MW-1:0]              nmag_q;
	bgi_pkg::result_t           res_q;

	logic [31:0] t_rdata, z_rdata, g_rdata;
	logic [TAW-1:0] t_raddr, g_tsel;
	logic [ZAW-1:0] z_raddr, g_zsel;
	logic [GAW-1:0] g_raddr, g_waddr;
	logic t_we, z_we, g_we, is_load;
	logic t_done, z_done, degen;
	logic [32:0] dth_c, dtl_c, dzh_c, dzl_c, ddt_c, ddz_c;
	logic [31:0] gv, vm, mul_a, mul_b;
	logic        tneg;
	logic [AW-1:0] term_ext;
	logic        div_start;
	logic [bgi_pkg::QUO_W-1:0] quo;
	bgi_pkg::div_stat_t div_stat;
	bgi_pkg::result_t   div_res;

	assign cfg_ready = 1'b1;
	assign res = res_q;

	always_comb begin
		if (theta_used_q < bgi_pkg::TUSED_W'(2)) begin
			nt_c = NTW'(2);
		end else if (int'(theta_used_q) > THETA_POINTS) begin
			nt_c = NTW'(THETA_POINTS);
		end else begin
			nt_c = NTW'(theta_used_q);
		end
		if (z_used_q < bgi_pkg::ZUSED_W'(2)) begin
			nz_c = NZW'(2);
		end else if (int'(z_used_q) > Z_POINTS) begin
			nz_c = NZW'(Z_POINTS);
		end else begin
			nz_c = NZW'(z_used_q);
		end
	end

	// stores: loads write from the head of the command queue
	assign is_load = (state_q == bgi_pkg::ST_IDLE) && !cmd_empty;
	assign t_we = is_load && (cmd.op == bgi_pkg::KIND_LOAD_THETA);
	assign z_we = is_load && (cmd.op == bgi_pkg::KIND_LOAD_Z);
	assign g_we = is_load && (cmd.op == bgi_pkg::KIND_LOAD_GRID);
	assign g_waddr = GAW'(ZAW'(cmd.zidx)) * GAW'(THETA_POINTS) + GAW'(TAW'(cmd.tidx));

	// fetch step k: 0 low corners, 1 high axis points, grid walks the four corners
	always_comb begin
		t_raddr = TAW'(ti_q);
		z_raddr = ZAW'(zi_q);
		if (state_q == bgi_pkg::ST_FETCH && k_q != 3'd0) begin
			t_raddr = TAW'(ti_q) + TAW'(1);
			z_raddr = ZAW'(zi_q) + ZAW'(1);
		end
		g_tsel = TAW'(ti_q) + TAW'(k_q[0]);
		g_zsel = ZAW'(zi_q) + ZAW'(k_q[1]);
	end
	assign g_raddr = GAW'(g_zsel) * GAW'(THETA_POINTS) + GAW'(g_tsel);

	bgi_ram #(.W(32), .DEPTH(THETA_POINTS)) u_theta_ram (
		.clk(clk), .we(t_we), .waddr(TAW'(cmd.tidx)), .wdata(cmd.opa),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	bgi_ram #(.W(32), .DEPTH(Z_POINTS)) u_z_ram (
		.clk(clk), .we(z_we), .waddr(ZAW'(cmd.zidx)), .wdata(cmd.opa),
		.raddr(z_raddr), .rdata(z_rdata)
	);

	bgi_ram #(.W(32), .DEPTH(GDEPTH)) u_grid_ram (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(cmd.opa),
		.raddr(g_raddr), .rdata(g_rdata)
	);

	// lower bracket index ends as i-1 whether the point was found or the axis ran out
	assign t_done = ($signed(qt_q) < $signed(t_rdata)) || (ti_q == nt_q - NTW'(1));
	assign z_done = ($signed(qz_q) < $signed(z_rdata)) || (zi_q == nz_q - NZW'(1));

	assign dth_c = {thi_q[31], thi_q} - {qt_q[31], qt_q};
	assign dtl_c = {qt_q[31], qt_q} - {tlo_q[31], tlo_q};
	assign dzh_c = {zhi_q[31], zhi_q} - {qz_q[31], qz_q};
	assign dzl_c = {qz_q[31], qz_q} - {zlo_q[31], zlo_q};
	assign ddt_c = {thi_q[31], thi_q} - {tlo_q[31], tlo_q};
	assign ddz_c = {zhi_q[31], zhi_q} - {zlo_q[31], zlo_q};
	assign degen = (thi_q == tlo_q) || (zhi_q == zlo_q);

	assign gv = g_q[j_q];
	assign vm = bgi_pkg::mag32(gv);
	assign tneg = gv[31] ^ (j_q[1] ? dzl_s_q : dzh_s_q) ^ (j_q[0] ? dtl_s_q : dth_s_q);
	assign term_ext = {{(AW - bgi_pkg::TERM_W){1'b0}}, term_q};

	// one term: |dz|*|dt|, then times |v| in two 32-bit halves
	always_comb begin
		mul_a = ddt_m_q;
		mul_b = ddz_m_q;
		if (state_q == bgi_pkg::ST_MAC) begin
			case (ph_q)
				3'd0: begin
					mul_a = j_q[1] ? dzl_m_q : dzh_m_q;
					mul_b = j_q[0] ? dtl_m_q : dth_m_q;
				end
				3'd1: begin
					mul_a = prod_q[31:0];
					mul_b = vm;
				end
				default: begin
					mul_a = mhi_q;
					mul_b = vm;
				end
			endcase
		end
	end

	always_comb begin
		div_res.degenerate_cell = 1'b0;
		if (!qneg_q) begin
			div_res.saturated = div_stat.big || quo[31];
			div_res.interpolated = div_res.saturated ? bgi_pkg::POS_MAX : quo;
		end else begin
			div_res.saturated = div_stat.big || (quo > bgi_pkg::NEG_MIN);
			div_res.interpolated = div_res.saturated ? bgi_pkg::NEG_MIN : (~quo + 32'd1);
		end
	end

	bgi_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(nmag_q),
		.den(den_q),
		.quo(quo),
		.stat(div_stat)
	);

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		res_push = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			bgi_pkg::ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					if (cmd.op == bgi_pkg::KIND_QUERY) begin
						state_d = bgi_pkg::ST_TRD;
					end
				end
			end
			bgi_pkg::ST_TRD: state_d = bgi_pkg::ST_TCMP;
			bgi_pkg::ST_TCMP: state_d = t_done ? bgi_pkg::ST_ZRD : bgi_pkg::ST_TRD;
			bgi_pkg::ST_ZRD: state_d = bgi_pkg::ST_ZCMP;
			bgi_pkg::ST_ZCMP: state_d = z_done ? bgi_pkg::ST_FETCH : bgi_pkg::ST_ZRD;
			bgi_pkg::ST_FETCH: begin
				if (k_q == 3'd4) begin
					state_d = bgi_pkg::ST_DIFF;
				end
			end
			bgi_pkg::ST_DIFF: state_d = degen ? bgi_pkg::ST_OUT : bgi_pkg::ST_DEN;
			bgi_pkg::ST_DEN: state_d = bgi_pkg::ST_DEN2;
			bgi_pkg::ST_DEN2: state_d = bgi_pkg::ST_MAC;
			bgi_pkg::ST_MAC: begin
				if (ph_q == 3'd4 && j_q == 2'd3) begin
					state_d = bgi_pkg::ST_NORM;
				end
			end
			bgi_pkg::ST_NORM: state_d = bgi_pkg::ST_DSTART;
			bgi_pkg::ST_DSTART: begin
				div_start = 1'b1;
				state_d = bgi_pkg::ST_DIV;
			end
			bgi_pkg::ST_DIV: begin
				if (!div_stat.busy) begin
					state_d = bgi_pkg::ST_OUT;
				end
			end
			bgi_pkg::ST_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d = bgi_pkg::ST_IDLE;
				end
			end
			default: state_d = bgi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bgi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_used_q <= bgi_pkg::THETA_USED_RST;
			z_used_q <= bgi_pkg::Z_USED_RST;
			nt_q <= NTW'(2);
			nz_q <= NZW'(2);
			ti_q <= '0;
			zi_q <= '0;
			k_q <= '0;
			j_q <= '0;
			ph_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					bgi_pkg::REG_THETA_USED: theta_used_q <= cfg_data;
					bgi_pkg::REG_Z_USED:     z_used_q <= cfg_data[bgi_pkg::ZUSED_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				bgi_pkg::ST_IDLE: begin
					nt_q <= nt_c;
					nz_q <= nz_c;
					ti_q <= NTW'(1);
				end
				bgi_pkg::ST_TCMP: begin
					if (t_done) begin
						ti_q <= ti_q - NTW'(1);
						zi_q <= NZW'(1);
					end else begin
						ti_q <= ti_q + NTW'(1);
					end
				end
				bgi_pkg::ST_ZCMP: begin
					k_q <= '0;
					if (z_done) begin
						zi_q <= zi_q - NZW'(1);
					end else begin
						zi_q <= zi_q + NZW'(1);
					end
				end
				bgi_pkg::ST_FETCH: k_q <= k_q + 3'd1;
				bgi_pkg::ST_DEN2: begin
					j_q <= '0;
					ph_q <= '0;
				end
				bgi_pkg::ST_MAC: begin
					if (ph_q == 3'd4) begin
						ph_q <= '0;
						j_q <= j_q + 2'd1;
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			bgi_pkg::ST_IDLE: begin
				qt_q <= cmd.opa;
				qz_q <= cmd.opb;
			end
			bgi_pkg::ST_FETCH: begin
				case (k_q)
					3'd1: begin
						tlo_q <= t_rdata;
						zlo_q <= z_rdata;
						g_q[0] <= g_rdata;
					end
					3'd2: begin
						thi_q <= t_rdata;
						zhi_q <= z_rdata;
						g_q[1] <= g_rdata;
					end
					3'd3: g_q[2] <= g_rdata;
					3'd4: g_q[3] <= g_rdata;
					default: ;
				endcase
			end
			bgi_pkg::ST_DIFF: begin
				dth_m_q <= bgi_pkg::mag33(dth_c);
				dtl_m_q <= bgi_pkg::mag33(dtl_c);
				dzh_m_q <= bgi_pkg::mag33(dzh_c);
				dzl_m_q <= bgi_pkg::mag33(dzl_c);
				ddt_m_q <= bgi_pkg::mag33(ddt_c);
				ddz_m_q <= bgi_pkg::mag33(ddz_c);
				dth_s_q <= dth_c[32];
				dtl_s_q <= dtl_c[32];
				dzh_s_q <= dzh_c[32];
				dzl_s_q <= dzl_c[32];
				dneg_q <= ddt_c[32] ^ ddz_c[32];
				res_q.interpolated <= '0;
				res_q.saturated <= 1'b0;
				res_q.degenerate_cell <= 1'b1;
			end
			bgi_pkg::ST_DEN2: begin
				den_q <= prod_q;
				acc_q <= '0;
			end
			bgi_pkg::ST_MAC: begin
				case (ph_q)
					3'd1: mhi_q <= prod_q[63:32];
					3'd2: term_q <= {32'd0, prod_q};
					3'd3: term_q <= term_q + {prod_q, 32'd0};
					3'd4: acc_q <= acc_q + (tneg ? (~term_ext + AW'(1)) : term_ext);
					default: ;
				endcase
			end
			bgi_pkg::ST_NORM: begin
				nmag_q <= acc_q[AW-1] ? MW'(~acc_q + AW'(1)) : acc_q[MW-1:0];
				qneg_q <= acc_q[AW-1] ^ dneg_q;
			end
			bgi_pkg::ST_DIV: begin
				if (!div_stat.busy) begin
					res_q <= div_res;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> src/bilinear_grid_interpolator_core.sv
// Bilinear interpolator over a rectilinear (theta, z) grid, signed Q16.16.
// Input side is a queue: drive item and push while full is low. Load words
// write the theta axis, the z axis or the grid; query words produce one
// result word, loads produce none. Output side is a queue too: a result sits
// on result while empty is low and leaves on pop.
// Config: cfg_valid/cfg_ready write theta_points_used (index 0) or
// z_points_used (index 1); cfg_ready is always high. Write only when idle.
// Words pass a two-entry command queue into the execution engine, which
// handles one word at a time. A load writes its store straight from the
// queue head. A query runs a linear bracket search on each axis RAM, the
// corner fetch, the four products on the shared 32x32 multiplier and the
// bit-serial divider; a zero-area cell skips the products and divider.
// Results wait in a two-entry queue, so a stalled receiver only stops the
// engine once that queue is full; the command queue keeps taking words
// meanwhile, until it too is full. Reset empties both queues, returns the
// engine to idle and the point counts to 64 and 16; the stores keep no
// valid bits and must be written before a query reads them.
module bilinear_grid_interpolator_core #(
	parameter int THETA_POINTS = bgi_pkg::THETA_POINTS_DEF,
	parameter int Z_POINTS = bgi_pkg::Z_POINTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  bgi_pkg::item_t            item,
	output logic                      empty,
	input  logic                      pop,
	output bgi_pkg::result_t          result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  bgi_pkg::reg_idx_t         cfg_index,
	input  logic [bgi_pkg::CFG_W-1:0] cfg_data
);

	bgi_pkg::cmd_t    cmd;
	logic             cmd_empty, cmd_pop;
	bgi_pkg::result_t res;
	logic             res_push, res_full;

	bgi_front #(
		.THETA_POINTS(THETA_POINTS),
		.Z_POINTS(Z_POINTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.cmd_pop(cmd_pop),
		.cmd(cmd),
		.cmd_empty(cmd_empty)
	);

	bgi_back #(
		.THETA_POINTS(THETA_POINTS),
		.Z_POINTS(Z_POINTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.res(res),
		.res_push(res_push),
		.res_full(res_full)
	);

	bgi_fifo #(
		.W($bits(bgi_pkg::result_t)),
		.DEPTH(bgi_pkg::RES_DEPTH)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(res_push),
		.wr_data(res),
		.full(res_full),
		.rd_en(pop),
		.rd_data(result),
		.empty(empty)
	);

endmodule

>>> src/bgi_checker.sv
module bgi_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      push,
	input logic                      full,
	input bgi_pkg::item_t            item,
	input logic                      empty,
	input logic                      pop,
	input bgi_pkg::result_t          result
);

	logic [3:0] pend_q;
	logic       q_in, r_out;

	assign q_in = push && !full && (item.kind == bgi_pkg::KIND_QUERY);
	assign r_out = pop && !empty;

	// queries accepted but not yet popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({q_in, r_out})
				2'b10: pend_q <= pend_q + 4'd1;
				2'b01: pend_q <= pend_q - 4'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 4'd0)
		else $error("result word with no query outstanding");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.degenerate_cell) |-> (result.interpolated == '0 && !result.saturated))
		else $error("degenerate cell result not zero");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.saturated) |->
		(result.interpolated == bgi_pkg::POS_MAX || result.interpolated == bgi_pkg::NEG_MIN))
		else $error("saturated result not at a limit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result word changed while stalled");

endmodule

bind bilinear_grid_interpolator_core bgi_checker u_bgi_checker (
	.clk(clk),
	.arst_n(arst_n),
	.push(push),
	.full(full),
	.item(item),
	.empty(empty),
	.pop(pop),
	.result(result)
);

>>> tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	bgi_pkg::item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	bgi_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	bgi_pkg::reg_idx_t cfg_index = bgi_pkg::REG_THETA_USED;
	logic [bgi_pkg::CFG_W-1:0] cfg_data = '0;

	bilinear_grid_interpolator_core dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6ns clk = 1'b1;
		#6ns clk = 1'b0;
	end

	// predictor copy of the block's stores and point counts
	logic signed [31:0] theta_pts [64];
	logic signed [31:0] z_pts [16];
	logic signed [31:0] grid [1024];
	logic [bgi_pkg::TUSED_W-1:0] theta_used = bgi_pkg::THETA_USED_RST;
	logic [bgi_pkg::ZUSED_W-1:0] z_used = bgi_pkg::Z_USED_RST;

	bgi_pkg::item_t pending_words [$];
	bgi_pkg::result_t expected_results [$];
	int errors = 0;
	int n_results = 0;
	bit calm = 1'b0;
	logic word_taken = 1'b0;

	function automatic int used_theta();
		return theta_used < 2 ? 2 : (theta_used > 64 ? 64 : int'(theta_used));
	endfunction

	function automatic int used_z();
		return z_used < 2 ? 2 : (z_used > 16 ? 16 : int'(z_used));
	endfunction

	function automatic int bracket(input int n, input logic signed [31:0] x, input bit is_theta);
		int r;
		bit hit;
		logic signed [31:0] p;
		r = n - 1;
		hit = 1'b0;
		for (int i = 1; i < n; i++) begin
			p = is_theta ? theta_pts[i] : z_pts[i];
			if (!hit && x < p) begin
				r = i - 1;
				hit = 1'b1;
			end
		end
		if (r > n - 2) r = n - 2;
		return r;
	endfunction

	function automatic bgi_pkg::result_t interpolate(input bgi_pkg::item_t w);
		bgi_pkg::result_t r;
		int nt, nz, ti, zi;
		logic signed [127:0] tlo, thi, zlo, zhi, t, z, num, area, q, g;
		nt = used_theta();
		nz = used_z();
		ti = bracket(nt, w.query_theta, 1'b1);
		zi = bracket(nz, w.query_z, 1'b0);
		tlo = theta_pts[ti];
		thi = theta_pts[ti + 1];
		zlo = z_pts[zi];
		zhi = z_pts[zi + 1];
		t = w.query_theta;
		z = w.query_z;
		r = '0;
		if (thi == tlo || zhi == zlo) begin
			r.degenerate_cell = 1'b1;
			return r;
		end
		g = grid[zi * 64 + ti];
		num = g * (zhi - z) * (thi - t);
		g = grid[zi * 64 + ti + 1];
		num += g * (zhi - z) * (t - tlo);
		g = grid[(zi + 1) * 64 + ti];
		num += g * (z - zlo) * (thi - t);
		g = grid[(zi + 1) * 64 + ti + 1];
		num += g * (z - zlo) * (t - tlo);
		area = (thi - tlo) * (zhi - zlo);
		q = num / area;
		if (q > 128'sh7FFF_FFFF) begin
			r.interpolated = bgi_pkg::POS_MAX;
			r.saturated = 1'b1;
		end else if (q < -128'sh8000_0000) begin
			r.interpolated = bgi_pkg::NEG_MIN;
			r.saturated = 1'b1;
		end else begin
			r.interpolated = q[31:0];
		end
		return r;
	endfunction

	task automatic apply_word(input bgi_pkg::item_t w);
		case (w.kind)
			bgi_pkg::KIND_LOAD_THETA: theta_pts[w.theta_index] = w.load_value;
			bgi_pkg::KIND_LOAD_Z: z_pts[w.z_index] = w.load_value;
			bgi_pkg::KIND_LOAD_GRID: grid[{w.z_index, w.theta_index}] = w.load_value;
			default: expected_results.push_back(interpolate(w));
		endcase
	endtask

	// input side
	always @(negedge clk) begin
		int gap;
		if (word_taken) pending_words.pop_front();
		if (gap > 0) begin
			gap--;
			push <= 1'b0;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			gap = $urandom_range(0, 15);
			push <= 1'b0;
		end else if (pending_words.size() > 0) begin
			push <= 1'b1;
			item <= pending_words[0];
		end else begin
			push <= 1'b0;
		end
	end

	// output side, with one long hold-off to back the block up
	always @(negedge clk) begin
		int gap;
		int hold;
		bit hold_done;
		if (!hold_done && n_results >= 30) begin
			hold_done = 1'b1;
			hold = 2000;
		end
		if (hold > 0) begin
			hold--;
			pop <= 1'b0;
		end else if (gap > 0) begin
			gap--;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			gap = $urandom_range(0, 15);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		bgi_pkg::result_t want;
		word_taken <= push && !full;
		if (push && !full) apply_word(item);
		if (pop && !empty) begin
			n_results++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word %h", $time, result);
			end else begin
				want = expected_results.pop_front();
				if (result.interpolated !== want.interpolated) begin
					errors++;
					$display("%0t: interpolated expected %h actual %h", $time,
						want.interpolated, result.interpolated);
				end
				if (result.saturated !== want.saturated) begin
					errors++;
					$display("%0t: saturated expected %b actual %b", $time,
						want.saturated, result.saturated);
				end
				if (result.degenerate_cell !== want.degenerate_cell) begin
					errors++;
					$display("%0t: degenerate_cell expected %b actual %b", $time,
						want.degenerate_cell, result.degenerate_cell);
				end
			end
		end
	end

	function automatic bgi_pkg::item_t mk_word(input bgi_pkg::kind_t k, input int ti,
			input int zi, input logic [31:0] lv, input logic [31:0] qt,
			input logic [31:0] qz);
		bgi_pkg::item_t w;
		w.kind = k;
		w.theta_index = 6'(ti);
		w.z_index = 4'(zi);
		w.load_value = lv;
		w.query_theta = qt;
		w.query_z = qz;
		return w;
	endfunction

	function automatic bgi_pkg::item_t rnd_word(input bgi_pkg::kind_t k);
		return mk_word(k, $urandom_range(0, 63), $urandom_range(0, 15),
			$urandom, $urandom, $urandom);
	endfunction

	task automatic drain();
		while (pending_words.size() != 0 || push || expected_results.size() != 0)
			@(posedge clk);
		// a trailing load may still be in the engine
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input bgi_pkg::reg_idx_t idx, input int v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= bgi_pkg::CFG_W'(v);
		do @(posedge clk); while (!cfg_ready);
		if (idx == bgi_pkg::REG_THETA_USED) theta_used = bgi_pkg::TUSED_W'(v);
		else z_used = bgi_pkg::ZUSED_W'(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// style 0 sorted, 1 sorted with repeated points, 2 unsorted, 3 fine steps;
	// only the points in use are reloaded
	task automatic load_axes(input int style);
		logic signed [31:0] p;
		int nt, nz;
		nt = used_theta();
		nz = used_z();
		for (int i = 0; i < nt + nz; i++) begin
			if (i == 0 || i == nt)
				p = -$signed(32'($urandom_range(0, 32'h3FFF_FFFF)));
			else if (style == 2)
				p = $urandom;
			else if (style == 3)
				p = p + $urandom_range(1, 4);
			else if (style == 1 && $urandom_range(0, 3) == 0)
				p = p;
			else
				p = p + $urandom_range(1, 32'h01FF_FFFF);
			if (i < nt)
				pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_THETA, i, 0, p,
					$urandom, $urandom));
			else
				pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_Z, 0, i - nt, p,
					$urandom, $urandom));
		end
	endtask

	function automatic logic [31:0] pick_coord(input bit is_theta);
		logic [31:0] p;
		p = is_theta ? theta_pts[$urandom_range(0, 63)] : z_pts[$urandom_range(0, 15)];
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: return p;
			3: return $urandom_range(0, 1) ? bgi_pkg::POS_MAX : bgi_pkg::NEG_MIN;
			default: return p + $signed(32'($urandom_range(0, 32'h0002_0000))) - 32'h0001_0000;
		endcase
	endfunction

	task automatic random_words(input int n);
		bgi_pkg::item_t w;
		repeat (n) begin
			case ($urandom_range(0, 19))
				0: w = rnd_word(bgi_pkg::KIND_LOAD_THETA);
				1: w = rnd_word(bgi_pkg::KIND_LOAD_Z);
				2, 3, 4, 5: begin
					w = rnd_word(bgi_pkg::KIND_LOAD_GRID);
					if ($urandom_range(0, 2) == 0) w.load_value = $signed(8'($urandom)) <<< 16;
				end
				default: begin
					w = rnd_word(bgi_pkg::KIND_QUERY);
					w.query_theta = pick_coord(1'b1);
					w.query_z = pick_coord(1'b0);
				end
			endcase
			pending_words.push_back(w);
			// keep the predictor current for coordinate picks
			while (pending_words.size() > 4) @(posedge clk);
		end
	endtask

	// a wide theta range goes with a short z range and the other way round,
	// so queries only touch the grid rows and columns filled below
	int tset [8] = '{64, 2, 127, 0, 1, 33, 65, 2};
	int zset [8] = '{2, 16, 0, 31, 2, 1, 0, 17};

	initial begin
		for (int i = 0; i < 1024; i++) grid[i] = '0;
		for (int i = 0; i < 64; i++) theta_pts[i] = '0;
		for (int i = 0; i < 16; i++) z_pts[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// axes in full; grid rows 0 and 1 across theta, columns 0 and 1 across z
		for (int i = 0; i < 64; i++)
			pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_THETA, i, 0, i << 16,
				$urandom, $urandom));
		for (int i = 0; i < 16; i++)
			pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_Z, 0, i, i << 16,
				$urandom, $urandom));
		for (int i = 0; i < 128; i++)
			pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_GRID, i % 64, i / 64,
				$urandom, $urandom, $urandom));
		for (int i = 4; i < 32; i++)
			pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_GRID, i % 2, i / 2,
				$urandom, $urandom, $urandom));
		pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_GRID, 0, 0, bgi_pkg::POS_MAX, 0, 0));
		pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_GRID, 1, 0, bgi_pkg::NEG_MIN, 0, 0));
		pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_GRID, 63, 1, bgi_pkg::POS_MAX, 0, 0));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0, 0, 0));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0,
			32'h0000_8000, 32'h0000_8000));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0, 63 << 16, 0));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0, 0, 15 << 16));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0,
			bgi_pkg::NEG_MIN, bgi_pkg::NEG_MIN));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0,
			bgi_pkg::POS_MAX, bgi_pkg::NEG_MIN));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0,
			bgi_pkg::NEG_MIN, bgi_pkg::POS_MAX));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0, bgi_pkg::NEG_MIN, 0));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0,
			70 << 16, 32'h0000_8000));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0,
			32'h0010_1234, 32'h0000_C000));
		// zero-area cell on each axis; only the theta point is restored
		pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_THETA, 1, 0, 0, 0, 0));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0,
			32'h0000_8000, 32'h0000_8000));
		pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_THETA, 1, 0, 1 << 16, 0, 0));
		pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_Z, 0, 15, 14 << 16, 0, 0));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0,
			32'h0000_8000, bgi_pkg::POS_MAX));
		// unsorted axis
		pending_words.push_back(mk_word(bgi_pkg::KIND_LOAD_THETA, 5, 0, -(3 << 16), 0, 0));
		pending_words.push_back(mk_word(bgi_pkg::KIND_QUERY, 0, 0, 0,
			32'h0004_8000, 32'h0000_8000));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(bgi_pkg::REG_THETA_USED, tset[ph]);
			write_reg(bgi_pkg::REG_Z_USED, zset[ph]);
			if (ph == 7) calm = 1'b1;
			load_axes(ph % 4);
			random_words(14);
			drain();
		end

		if (errors == 0 && expected_results.size() == 0) begin
			$display("bilinear_grid_interpolator_core test passed");
		end else begin
			$display("bilinear_grid_interpolator_core test failed");
		end
		$finish;
	end

	initial begin
		#(12ns * 4_000_000);
		$display("bilinear_grid_interpolator_core test failed");
		$finish;
	end

endmodule
